// ===== rtl/icst_pkg.sv =====
package icst_pkg;

  localparam logic [2:0] MODE_BTN_DOWN = 3'd0;
  localparam logic [2:0] MODE_BTN_UP   = 3'd1;
  localparam logic [2:0] MODE_PTR_DOWN = 3'd2;
  localparam logic [2:0] MODE_PTR_MOVE = 3'd3;
  localparam logic [2:0] MODE_PTR_UP   = 3'd4;
  localparam logic [2:0] MODE_REL_ALL  = 3'd5;

  localparam logic [1:0] KIND_VERDICT = 2'd0;
  localparam logic [1:0] KIND_BTN_REL = 2'd1;
  localparam logic [1:0] KIND_PTR_REL = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

  localparam logic [3:0] BUTTONS_RESET = 4'd8;

  typedef struct packed {
    logic [2:0]         mode;
    logic [1:0]         source;
    logic [7:0]         button_index;
    logic [3:0]         contact_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        time_ms;
    logic [7:0]         queue_space;
  } req_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               accepted;
    logic [2:0]         out_button;
    logic [3:0]         out_contact;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [1:0]         out_source;
    logic [31:0]        out_time;
    logic [3:0]         released_count;
    logic               last;
  } rsp_t;

endpackage

// ===== rtl/input_contact_state_tracker.sv =====
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  icst_pkg::req_t
// out      output     out_valid_o / out_ready_i icst_pkg::rsp_t
// cfg      input      cfg_we_i (no wait)       cfg_wdata_i, buttons in profile
// One request at a time: a button or pointer event is accepted, then checked.
// Release all: the sequencer walks one button per cycle, unless stalled, through
// the shared index and compare, then the pointer, then the count.
// A result waiting in the output register stalls the walk only when a new
// result must be written. Reset clears all held state; profile resets to 8.
module input_contact_state_tracker #(
  parameter int MAX_BUTTONS      = 8,
  parameter int MAX_TOUCH_POINTS = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  icst_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output icst_pkg::rsp_t out_rsp_o,
  input  logic           cfg_we_i,
  input  logic [3:0]     cfg_wdata_i
);
  import icst_pkg::*;

  localparam int BW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam logic [BW-1:0] LAST_IDX = BW'(MAX_BUTTONS - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_SCAN = 5'b00100,
    S_PTR  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  req_t                   req_q, req_d;
  logic [MAX_BUTTONS-1:0] held_q, held_d;
  logic [1:0]             held_by_q [MAX_BUTTONS];
  logic [1:0]             held_by_d [MAX_BUTTONS];
  logic                   ca_q, ca_d;
  logic [3:0]             cnum_q, cnum_d;
  logic signed [15:0]     cx_q, cx_d, cy_q, cy_d;
  logic [1:0]             csrc_q, csrc_d;
  logic [3:0]             bip_q, bip_d;
  logic [BW-1:0]          idx_q, idx_d;
  logic [7:0]             space_q, space_d;
  logic [3:0]             cnt_q, cnt_d;
  rsp_t                   out_q, out_d;
  logic                   out_vld_q, out_vld_d;

  logic slot_free;
  logic btn_ok;
  logic hit_btn;
  logic hit_ptr;
  logic ptr_match;
  logic ok;

  assign slot_free   = !out_vld_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  assign btn_ok    = (req_q.button_index < {4'b0, bip_q}) &&
                     (req_q.button_index < 8'(MAX_BUTTONS));
  assign hit_btn   = held_q[idx_q] && (held_by_q[idx_q] == req_q.source) &&
                     (space_q != 8'd0);
  assign hit_ptr   = ca_q && (csrc_q == req_q.source) && (space_q != 8'd0);
  assign ptr_match = ca_q && (req_q.contact_id == cnum_q);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    held_d    = held_q;
    held_by_d = held_by_q;
    ca_d      = ca_q;
    cnum_d    = cnum_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    csrc_d    = csrc_q;
    bip_d     = cfg_we_i ? cfg_wdata_i : bip_q;
    idx_d     = idx_q;
    space_d   = space_q;
    cnt_d     = cnt_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_ready_i;
    ok        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          idx_d   = (in_req_i.mode == MODE_REL_ALL) ? '0 : in_req_i.button_index[BW-1:0];
          space_d = in_req_i.queue_space;
          cnt_d   = '0;
          state_d = (in_req_i.mode == MODE_REL_ALL) ? S_SCAN : S_EVAL;
        end
      end
      S_EVAL: begin
        if (slot_free) begin
          case (req_q.mode) inside
            MODE_BTN_DOWN: begin
              ok = btn_ok && !held_q[idx_q];
              if (ok) begin
                held_d[idx_q]    = 1'b1;
                held_by_d[idx_q] = req_q.source;
              end
            end
            MODE_BTN_UP: begin
              ok = btn_ok && held_q[idx_q];
              if (ok) held_d[idx_q] = 1'b0;
            end
            MODE_PTR_DOWN: begin
              ok = ({1'b0, req_q.contact_id} < 5'(MAX_TOUCH_POINTS)) && !ca_q;
              if (ok) begin
                ca_d   = 1'b1;
                cnum_d = req_q.contact_id;
                cx_d   = req_q.pos_x;
                cy_d   = req_q.pos_y;
                csrc_d = req_q.source;
              end
            end
            MODE_PTR_MOVE, MODE_PTR_UP: begin
              ok = ptr_match;
              if (ok) begin
                cx_d = req_q.pos_x;
                cy_d = req_q.pos_y;
                if (req_q.mode == MODE_PTR_UP) ca_d = 1'b0;
              end
            end
            default: ok = 1'b0;
          endcase
          out_d          = '0;
          out_d.kind     = KIND_VERDICT;
          out_d.accepted = ok;
          out_d.last     = 1'b1;
          out_vld_d      = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!hit_btn || slot_free) begin
          if (hit_btn) begin
            out_d            = '0;
            out_d.kind       = KIND_BTN_REL;
            out_d.out_button = 3'(idx_q);
            out_d.out_source = req_q.source;
            out_d.out_time   = req_q.time_ms;
            out_vld_d        = 1'b1;
            held_d[idx_q]    = 1'b0;
            space_d          = space_q - 8'd1;
            cnt_d            = cnt_q + 4'd1;
          end
          if (idx_q == LAST_IDX) state_d = S_PTR;
          else                   idx_d   = idx_q + BW'(1);
        end
      end
      S_PTR: begin
        if (!hit_ptr || slot_free) begin
          if (hit_ptr) begin
            out_d             = '0;
            out_d.kind        = KIND_PTR_REL;
            out_d.out_contact = cnum_q;
            out_d.out_x       = cx_q;
            out_d.out_y       = cy_q;
            out_d.out_source  = req_q.source;
            out_d.out_time    = req_q.time_ms;
            out_vld_d         = 1'b1;
            ca_d              = 1'b0;
            space_d           = space_q - 8'd1;
            cnt_d             = cnt_q + 4'd1;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_d                = '0;
          out_d.kind           = KIND_DONE;
          out_d.released_count = cnt_q;
          out_d.last           = 1'b1;
          out_vld_d            = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      held_q    <= '0;
      for (int i = 0; i < MAX_BUTTONS; i++) held_by_q[i] <= 2'd0;
      ca_q      <= 1'b0;
      cnum_q    <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      csrc_q    <= '0;
      bip_q     <= BUTTONS_RESET;
      idx_q     <= '0;
      space_q   <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      held_by_q <= held_by_d;
      ca_q      <= ca_d;
      cnum_q    <= cnum_d;
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      csrc_q    <= csrc_d;
      bip_q     <= bip_d;
      idx_q     <= idx_d;
      space_q   <= space_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
  end

  a_mid_is_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.last) |->
      (out_q.kind == KIND_BTN_REL || out_q.kind == KIND_PTR_REL))
    else $error("non-final result is not a release");

  a_verdict_follows_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && slot_free) |=>
      (out_vld_q && out_q.last && out_q.kind == KIND_VERDICT && state_q == S_IDLE))
    else $error("verdict not issued after check");

  a_full_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && space_q == 8'd0) |=> $stable(held_q))
    else $error("button released with no queue space");

endmodule

// ===== sim/input_contact_state_tracker_tb.sv =====
`timescale 1ns / 1ps

module input_contact_state_tracker_tb;
  import icst_pkg::*;

  localparam int NUM_BUTTONS   = 8;
  localparam int NUM_TOUCH     = 1;
  localparam int SETTLE_CYCLES = NUM_BUTTONS + 12;
  localparam int PHASE_ITEMS   = 33;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  req_t       in_req_i;
  logic       out_valid_o;
  logic       out_ready_i;
  rsp_t       out_rsp_o;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;

  req_t pending_req[$];
  rsp_t expected_rsp[$];
  rsp_t want_rsp;
  int   mismatch_count;
  int   sender_idle_pct   = 19;
  int   receiver_idle_pct = 70;

  // shadow of the tracker state
  logic [3:0]  profile;
  logic        btn_held [NUM_BUTTONS];
  logic [1:0]  btn_owner[NUM_BUTTONS];
  logic        ptr_active;
  logic [3:0]  ptr_id;
  logic [15:0] ptr_x;
  logic [15:0] ptr_y;
  logic [1:0]  ptr_owner;

  input_contact_state_tracker #(
    .MAX_BUTTONS      (NUM_BUTTONS),
    .MAX_TOUCH_POINTS (NUM_TOUCH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic string rsp_str(input rsp_t r);
    return $sformatf({"kind=%0d acc=%0d btn=%0d id=%0d x=%0d y=%0d ",
                      "src=%0d t=%0h cnt=%0d last=%0d"},
                     r.kind, r.accepted, r.out_button, r.out_contact, r.out_x, r.out_y,
                     r.out_source, r.out_time, r.released_count, r.last);
  endfunction

  function automatic logic button_in_range(input logic [7:0] idx);
    return (idx < profile) && (idx < NUM_BUTTONS);
  endfunction

  task automatic reset_tracker();
    int i;
    profile = BUTTONS_RESET;
    for (i = 0; i < NUM_BUTTONS; i++) begin
      btn_held[i]  = 1'b0;
      btn_owner[i] = 2'd0;
    end
    ptr_active = 1'b0;
    ptr_id     = '0;
    ptr_x      = '0;
    ptr_y      = '0;
    ptr_owner  = '0;
  endtask

  task automatic track_request(input req_t r);
    rsp_t       e;
    logic       ok;
    logic [7:0] room;
    logic [3:0] cnt;
    int         i;
    e = '0;
    if (r.mode != MODE_REL_ALL) begin
      ok = 1'b0;
      case (r.mode) inside
        MODE_BTN_DOWN: begin
          if (button_in_range(r.button_index) && !btn_held[r.button_index[2:0]]) begin
            btn_held[r.button_index[2:0]]  = 1'b1;
            btn_owner[r.button_index[2:0]] = r.source;
            ok = 1'b1;
          end
        end
        MODE_BTN_UP: begin
          if (button_in_range(r.button_index) && btn_held[r.button_index[2:0]]) begin
            btn_held[r.button_index[2:0]] = 1'b0;
            ok = 1'b1;
          end
        end
        MODE_PTR_DOWN: begin
          if (r.contact_id < NUM_TOUCH && !ptr_active) begin
            ptr_active = 1'b1;
            ptr_id     = r.contact_id;
            ptr_x      = r.pos_x;
            ptr_y      = r.pos_y;
            ptr_owner  = r.source;
            ok = 1'b1;
          end
        end
        MODE_PTR_MOVE, MODE_PTR_UP: begin
          if (ptr_active && r.contact_id == ptr_id) begin
            ptr_x = r.pos_x;
            ptr_y = r.pos_y;
            if (r.mode == MODE_PTR_UP) ptr_active = 1'b0;
            ok = 1'b1;
          end
        end
        default: ok = 1'b0;
      endcase
      e.kind     = KIND_VERDICT;
      e.accepted = ok;
      e.last     = 1'b1;
      expected_rsp.push_back(e);
    end else begin
      room = r.queue_space;
      cnt  = '0;
      for (i = 0; i < NUM_BUTTONS; i++) begin
        if (btn_held[i] && btn_owner[i] == r.source && room != 0) begin
          e            = '0;
          e.kind       = KIND_BTN_REL;
          e.out_button = 3'(i);
          e.out_source = r.source;
          e.out_time   = r.time_ms;
          expected_rsp.push_back(e);
          btn_held[i] = 1'b0;
          room--;
          cnt++;
        end
      end
      if (ptr_active && ptr_owner == r.source && room != 0) begin
        e             = '0;
        e.kind        = KIND_PTR_REL;
        e.out_contact = ptr_id;
        e.out_x       = ptr_x;
        e.out_y       = ptr_y;
        e.out_source  = r.source;
        e.out_time    = r.time_ms;
        expected_rsp.push_back(e);
        ptr_active = 1'b0;
        cnt++;
      end
      e                = '0;
      e.kind           = KIND_DONE;
      e.released_count = cnt;
      e.last           = 1'b1;
      expected_rsp.push_back(e);
    end
  endtask

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
    end else begin
      if (in_valid_i && in_ready_o) track_request(in_req_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_req.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid_i <= 1'b1;
          in_req_i   <= pending_req.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= receiver_idle_pct);
      if (out_valid_o && out_ready_i) begin
        if (expected_rsp.size() == 0) begin
          log_mismatch($sformatf("unexpected result: %s", rsp_str(out_rsp_o)));
        end else begin
          want_rsp = expected_rsp.pop_front();
          if (out_rsp_o !== want_rsp)
            log_mismatch($sformatf("mismatch\n  exp: %s\n  got: %s",
                                   rsp_str(want_rsp), rsp_str(out_rsp_o)));
        end
      end
    end
  end

  function automatic req_t random_fields();
    req_t r;
    r.mode         = 3'($urandom);
    r.source       = 2'($urandom);
    r.button_index = 8'($urandom);
    r.contact_id   = 4'($urandom);
    r.pos_x        = 16'($urandom);
    r.pos_y        = 16'($urandom);
    r.time_ms      = $urandom;
    r.queue_space  = 8'($urandom);
    return r;
  endfunction

  task automatic queue_request(input logic [2:0] mode, input logic [1:0] src,
                               input logic [7:0] idx, input logic [3:0] cid,
                               input logic [15:0] x, input logic [15:0] y,
                               input logic [31:0] tm, input logic [7:0] space);
    req_t r;
    r.mode         = mode;
    r.source       = src;
    r.button_index = idx;
    r.contact_id   = cid;
    r.pos_x        = x;
    r.pos_y        = y;
    r.time_ms      = tm;
    r.queue_space  = space;
    pending_req.push_back(r);
  endtask

  // mostly well-formed traffic on a few sources and in-range indices, some noise
  function automatic req_t plausible_request();
    req_t r;
    int   pick;
    r    = random_fields();
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 3) != 0) r.source = 2'($urandom_range(0, 1));
    if ($urandom_range(0, 9) != 0) r.button_index = 8'($urandom_range(0, 8));
    if ($urandom_range(0, 9) != 0) r.contact_id = 4'd0;
    if (pick < 28) begin
      r.mode = MODE_BTN_DOWN;
    end else if (pick < 48) begin
      r.mode = MODE_BTN_UP;
    end else if (pick < 58) begin
      r.mode = MODE_PTR_DOWN;
    end else if (pick < 68) begin
      r.mode = MODE_PTR_MOVE;
    end else if (pick < 76) begin
      r.mode = MODE_PTR_UP;
    end else if (pick < 90) begin
      r.mode = MODE_REL_ALL;
      if ($urandom_range(0, 3) != 0) r.queue_space = 8'($urandom_range(0, 10));
    end
    return r;
  endfunction

  // press requests for every button and the pointer from one source, then release all
  task automatic queue_full_hold(input logic [1:0] src);
    int i;
    for (i = 0; i < NUM_BUTTONS; i++)
      queue_request(MODE_BTN_DOWN, src, 8'(i), 4'd0, 16'd0, 16'd0, 32'd0, 8'd0);
    queue_request(MODE_PTR_DOWN, src, 8'd0, 4'd0, 16'($urandom), 16'($urandom), 32'd0, 8'd0);
    queue_request(MODE_REL_ALL, src, 8'd0, 4'd0, 16'd0, 16'd0, $urandom, 8'd255);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_req.size() != 0 || in_valid_i || expected_rsp.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_profile(input logic [3:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    profile = value;
  endtask

  initial begin
    logic [3:0] profile_steps[6];
    int         ph;
    int         n;
    profile_steps = '{4'd5, 4'd0, 4'd8, 4'd15, 4'd1, 4'd8};
    mismatch_count = 0;
    reset_tracker();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_request(MODE_BTN_DOWN, 2'd0, 8'd0,   4'd0, 16'd0, 16'd0, 32'd0, 8'd0);
    queue_request(MODE_BTN_DOWN, 2'd1, 8'd7,   4'd0, 16'd0, 16'd0, 32'd0, 8'd0);
    queue_request(MODE_BTN_DOWN, 2'd1, 8'd7,   4'd0, 16'd0, 16'd0, 32'd0, 8'd0);
    queue_request(MODE_BTN_DOWN, 2'd0, 8'd8,   4'd0, 16'd0, 16'd0, 32'd0, 8'd0);
    queue_request(MODE_BTN_DOWN, 2'd3, 8'd255, 4'd0, 16'd0, 16'd0, 32'd0, 8'd0);
    queue_request(MODE_BTN_UP,   2'd0, 8'd3,   4'd0, 16'd0, 16'd0, 32'd0, 8'd0);
    queue_request(MODE_BTN_UP,   2'd0, 8'd0,   4'd0, 16'd0, 16'd0, 32'd0, 8'd0);
    queue_request(MODE_PTR_DOWN, 2'd1, 8'd0,   4'd1, 16'd5, 16'd5, 32'd0, 8'd0);
    queue_request(MODE_PTR_DOWN, 2'd1, 8'd0,   4'd0, 16'h8000, 16'h7fff, 32'd0, 8'd0);
    queue_request(MODE_PTR_DOWN, 2'd1, 8'd0,   4'd0, 16'd1, 16'd1, 32'd0, 8'd0);
    queue_request(MODE_PTR_MOVE, 2'd1, 8'd0,   4'd15, 16'd2, 16'd2, 32'd0, 8'd0);
    queue_request(MODE_PTR_MOVE, 2'd1, 8'd0,   4'd0, 16'h7fff, 16'h8000, 32'd0, 8'd0);
    queue_request(3'd6,          2'd2, 8'd1,   4'd0, 16'd0, 16'd0, 32'd0, 8'd0);
    queue_request(3'd7,          2'd3, 8'd1,   4'd0, 16'd0, 16'd0, 32'd0, 8'd0);
    queue_request(MODE_BTN_DOWN, 2'd1, 8'd2,   4'd0, 16'd0, 16'd0, 32'd0, 8'd0);
    queue_request(MODE_BTN_DOWN, 2'd1, 8'd4,   4'd0, 16'd0, 16'd0, 32'd0, 8'd0);
    queue_request(MODE_BTN_DOWN, 2'd2, 8'd5,   4'd0, 16'd0, 16'd0, 32'd0, 8'd0);
    // queue full after one release
    queue_request(MODE_REL_ALL,  2'd1, 8'd0,   4'd0, 16'd0, 16'd0, 32'h12345678, 8'd1);
    queue_request(MODE_REL_ALL,  2'd1, 8'd0,   4'd0, 16'd0, 16'd0, 32'hffffffff, 8'd255);
    queue_request(MODE_REL_ALL,  2'd2, 8'd0,   4'd0, 16'd0, 16'd0, 32'd7, 8'd0);
    queue_request(MODE_PTR_UP,   2'd1, 8'd0,   4'd0, 16'd0, 16'd0, 32'd0, 8'd0);
    queue_request(MODE_PTR_DOWN, 2'd3, 8'd0,   4'd0, 16'd10, 16'd20, 32'd0, 8'd0);
    queue_request(MODE_PTR_UP,   2'd3, 8'd0,   4'd0, 16'hfff0, 16'h0030, 32'd0, 8'd0);
    queue_request(MODE_REL_ALL,  2'd3, 8'd0,   4'd0, 16'd0, 16'd0, 32'd9, 8'd255);
    queue_request(MODE_REL_ALL,  2'd2, 8'd0,   4'd0, 16'd0, 16'd0, 32'd0, 8'd255);
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      write_profile(profile_steps[ph]);
      case (ph / 2)
        0: begin
          sender_idle_pct   = 19;
          receiver_idle_pct = 70;
        end
        1: begin
          sender_idle_pct   = 70;
          receiver_idle_pct = 19;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      queue_full_hold(2'(ph));
      for (n = 0; n < PHASE_ITEMS; n++) pending_req.push_back(plausible_request());
      wait_drained();
    end

    if (mismatch_count == 0 && expected_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/icst_pkg.sv
rtl/input_contact_state_tracker.sv
sim/input_contact_state_tracker_tb.sv
